>>> hw/rtl/word_request_coalescer_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the word request coalescer
// Clocked concurrent checks on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WORD_REQUEST_COALESCER_CORE_ASSERT_SVH
`define WORD_REQUEST_COALESCER_CORE_ASSERT_SVH

// Check that an expression holds at every clock edge.
`define WRC_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("word request coalescer: invariant violated");

// Check that a condition at one edge implies a consequence at the next edge.
`define WRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("word request coalescer: next-cycle check failed");

`endif

>>> hw/rtl/wrc_pkg.sv
// ----------------------------------------------------------------------------
// wrc_pkg
// Beat types, opcodes and arithmetic helpers of the word request coalescer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wrc_pkg;

    localparam int ADDR_W  = 32;
    localparam int GROUP_W = 16;
    localparam int MASK_W  = 64;
    localparam int USED_W  = 8;
    localparam int SUM_W   = 32;
    localparam int PC_W    = 7;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_END    = 1'b1;

    typedef struct packed {
        logic               op;
        logic [ADDR_W-1:0]  address;
        logic [GROUP_W-1:0] group;
        logic [MASK_W-1:0]  events;
    } req_beat_t;

    typedef struct packed {
        logic [ADDR_W-1:0] word_address;
        logic [USED_W-1:0] coefficients_used;
        logic [SUM_W-1:0]  event_updates;
        logic [SUM_W-1:0]  source_updates;
        logic [SUM_W-1:0]  total_requests;
        logic [SUM_W-1:0]  max_updates_per_word;
    } rec_beat_t;

    // Input stage contents handed to the merge unit.
    typedef struct packed {
        logic      vld;
        req_beat_t beat;
    } stage_t;

    // Merge unit result for the beat it consumes.
    typedef struct packed {
        logic      emit;
        rec_beat_t rec;
    } merge_res_t;

    // Adder tree: bit pairs, nibbles, bytes, then a balanced sum of the bytes.
    function automatic logic [PC_W-1:0] popcount64(input logic [MASK_W-1:0] v);
        logic [MASK_W-1:0] s2;
        logic [MASK_W-1:0] s4;
        logic [MASK_W-1:0] s8;
        s2 = (v & {32{2'b01}}) + ((v >> 1) & {32{2'b01}});
        s4 = (s2 & {16{4'h3}}) + ((s2 >> 2) & {16{4'h3}});
        s8 = (s4 & {8{8'h0F}}) + ((s4 >> 4) & {8{8'h0F}});
        return ((s8[6:0]   + s8[14:8])  + (s8[22:16] + s8[30:24])) +
               ((s8[38:32] + s8[46:40]) + (s8[54:48] + s8[62:56]));
    endfunction

    function automatic logic [SUM_W-1:0] sat_add32(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

>>> hw/rtl/wrc_in_stage.sv
// ----------------------------------------------------------------------------
// wrc_in_stage
// Input register: holds one request beat until the merge unit consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrc_in_stage
    import wrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_beat_t req_beat,
    input  logic      advance,
    output stage_t    stage
);

    logic      vld_reg;
    logic      vld_next;
    req_beat_t beat_reg;
    logic      take;

    // Stall only while a held beat cannot move on.
    assign req_stall = vld_reg && !advance;
    assign take      = req_valid && !req_stall;
    assign vld_next  = take ? 1'b1 : (advance ? 1'b0 : vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            beat_reg <= req_beat;
        end
    end

    assign stage.vld  = vld_reg;
    assign stage.beat = beat_reg;

endmodule

>>> hw/rtl/wrc_merge.sv
// ----------------------------------------------------------------------------
// wrc_merge
// Open-word state and single-pass merge logic; closes words into records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "word_request_coalescer_core_assert.svh"

module wrc_merge
    import wrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stage_t     stage,
    input  logic       advance,
    output merge_res_t res
);

    logic               open_valid_reg,  open_valid_next;
    logic [ADDR_W-1:0]  open_word_reg,   open_word_next;
    logic [GROUP_W-1:0] open_group_reg,  open_group_next;
    logic               group_valid_reg, group_valid_next;
    logic [USED_W-1:0]  used_count_reg,  used_count_next;
    logic [SUM_W-1:0]   update_sum_reg,  update_sum_next;
    logic [SUM_W-1:0]   source_sum_reg,  source_sum_next;
    logic [MASK_W-1:0]  group_mask_reg,  group_mask_next;
    logic [SUM_W-1:0]   request_total_reg, request_total_next;
    logic [SUM_W-1:0]   max_updates_reg,   max_updates_next;

    req_beat_t         b;
    logic              is_end;
    logic              new_word;
    logic              close;
    logic              group_change;
    logic [PC_W-1:0]   pc_mask;
    logic [PC_W-1:0]   pc_ev;
    logic [SUM_W-1:0]  src_close;
    logic [SUM_W-1:0]  req_inc;
    logic [SUM_W-1:0]  max_upd;
    logic [SUM_W-1:0]  upd_add;
    logic [USED_W-1:0] used_inc;

    assign b        = stage.beat;
    assign is_end   = (b.op == OP_END);
    assign new_word = !open_valid_reg || (b.address != open_word_reg);
    assign close    = open_valid_reg && (is_end || new_word);
    assign group_change = !group_valid_reg || (b.group != open_group_reg);

    assign pc_mask   = popcount64(group_mask_reg);
    assign pc_ev     = popcount64(b.events);
    assign src_close = sat_add32(source_sum_reg, {{(SUM_W-PC_W){1'b0}}, pc_mask});
    assign req_inc   = sat_add32(request_total_reg, {{(SUM_W-1){1'b0}}, 1'b1});
    assign max_upd   = (update_sum_reg > max_updates_reg) ? update_sum_reg
                                                           : max_updates_reg;
    assign upd_add   = sat_add32(update_sum_reg, {{(SUM_W-PC_W){1'b0}}, pc_ev});
    assign used_inc  = (used_count_reg == {USED_W{1'b1}}) ? used_count_reg
                                                           : used_count_reg + 1'b1;

    // Record of the word being closed by this beat.
    assign res.emit                     = advance && close;
    assign res.rec.word_address         = open_word_reg;
    assign res.rec.coefficients_used    = used_count_reg;
    assign res.rec.event_updates        = update_sum_reg;
    assign res.rec.source_updates       = src_close;
    assign res.rec.total_requests       = req_inc;
    assign res.rec.max_updates_per_word = max_upd;

    always_comb
    begin
        open_valid_next    = open_valid_reg;
        open_word_next     = open_word_reg;
        open_group_next    = open_group_reg;
        group_valid_next   = group_valid_reg;
        used_count_next    = used_count_reg;
        update_sum_next    = update_sum_reg;
        source_sum_next    = source_sum_reg;
        group_mask_next    = group_mask_reg;
        request_total_next = request_total_reg;
        max_updates_next   = max_updates_reg;

        if (advance)
        begin
            if (close)
            begin
                request_total_next = req_inc;
                max_updates_next   = max_upd;
            end
            if (is_end)
            begin
                // Drop the open word, if any.
                open_valid_next  = 1'b0;
                open_word_next   = '0;
                open_group_next  = '0;
                group_valid_next = 1'b0;
                used_count_next  = '0;
                update_sum_next  = '0;
                source_sum_next  = '0;
                group_mask_next  = '0;
            end
            else
            begin
                open_valid_next  = 1'b1;
                open_word_next   = b.address;
                open_group_next  = b.group;
                group_valid_next = 1'b1;
                if (new_word)
                begin
                    // Fresh word: the access starts a fresh group as well.
                    used_count_next = {{(USED_W-1){1'b0}}, 1'b1};
                    update_sum_next = {{(SUM_W-PC_W){1'b0}}, pc_ev};
                    source_sum_next = '0;
                    group_mask_next = b.events;
                end
                else
                begin
                    used_count_next = used_inc;
                    update_sum_next = upd_add;
                    if (group_change)
                    begin
                        source_sum_next = src_close;
                        group_mask_next = b.events;
                    end
                    else
                    begin
                        group_mask_next = group_mask_reg | b.events;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_valid_reg    <= 1'b0;
            open_word_reg     <= '0;
            open_group_reg    <= '0;
            group_valid_reg   <= 1'b0;
            used_count_reg    <= '0;
            update_sum_reg    <= '0;
            source_sum_reg    <= '0;
            group_mask_reg    <= '0;
            request_total_reg <= '0;
            max_updates_reg   <= '0;
        end
        else
        begin
            open_valid_reg    <= open_valid_next;
            open_word_reg     <= open_word_next;
            open_group_reg    <= open_group_next;
            group_valid_reg   <= group_valid_next;
            used_count_reg    <= used_count_next;
            update_sum_reg    <= update_sum_next;
            source_sum_reg    <= source_sum_next;
            group_mask_reg    <= group_mask_next;
            request_total_reg <= request_total_next;
            max_updates_reg   <= max_updates_next;
        end
    end

    `WRC_ASSERT_ALWAYS(a_emit_needs_open, !res.emit || open_valid_reg)
    `WRC_ASSERT_ALWAYS(a_used_tracks_open, open_valid_reg == (used_count_reg != '0))
    `WRC_ASSERT_ALWAYS(a_group_within_word, !group_valid_reg || open_valid_reg)
    `WRC_ASSERT_NEXT(a_access_opens, advance && stage.beat.op == OP_ACCESS, open_valid_reg)

endmodule

>>> hw/rtl/word_request_coalescer_core.sv
// ----------------------------------------------------------------------------
// word_request_coalescer_core
// Merges an ordered coefficient access stream into one request per word.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req_beat): one beat per access
//   (op = access) or an end-of-stage marker (op = end) that closes the open
//   word. Record channel (rec_valid / rec_stall / rec_beat): one beat per
//   closed word with its address, counts, running request total and the
//   largest per-word update count so far.
//   A beat is taken into the input register and merged against the open-word
//   state once the output register can take a record; a record of the word
//   that it closes is loaded into the output register as the beat is merged,
//   so the input and output registers lie between accept and record.
//   Throughput is one request beat per cycle while no record is stalled in
//   the output register, set by the single merge pass (64-bit popcounts, a
//   compare and saturating adds) between input, state and output registers.
//   A stalled record holds in the output register; the merge pass waits only
//   while that register is full and stalled, and the input register keeps
//   taking beats while it is empty or moving.
//   Reset closes any open word without a record and clears the request total
//   and the running maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module word_request_coalescer_core
    import wrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_beat_t req_beat,
    output logic      rec_valid,
    input  logic      rec_stall,
    output rec_beat_t rec_beat
);

    stage_t     stage;
    merge_res_t res;
    logic       advance;
    logic       rec_valid_reg;
    logic       rec_valid_next;
    rec_beat_t  rec_beat_reg;

    // Advance the held beat whenever the output register can take a record.
    assign advance = stage.vld && (!rec_valid_reg || !rec_stall);

    wrc_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_beat  (req_beat),
        .advance   (advance),
        .stage     (stage)
    );

    wrc_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .advance (advance),
        .res     (res)
    );

    // Load a new record, hold a stalled one, drop one that was taken.
    always_comb
    begin
        if (res.emit)
        begin
            rec_valid_next = 1'b1;
        end
        else if (rec_stall)
        begin
            rec_valid_next = rec_valid_reg;
        end
        else
        begin
            rec_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            rec_valid_reg <= rec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.emit)
        begin
            rec_beat_reg <= res.rec;
        end
    end

    assign rec_valid = rec_valid_reg;
    assign rec_beat  = rec_beat_reg;

endmodule

>>> tb/sv/word_request_coalescer_core_test.sv
// ----------------------------------------------------------------------------
// word_request_coalescer_core_test
// Self-checking bench: drives access and end beats, predicts each record.
// ----------------------------------------------------------------------------
// A behavioral predictor keeps its own copy of the open-word state and
// computes the record that each accepted request beat closes. A checker
// process compares every accepted record beat, field by field, with the
// oldest prediction. The stimulus is a directed pass over the corner cases,
// then word runs with random content, a long receiver hold-off, a word long
// enough to saturate the used count, a full drain, and a final stretch with
// no idling on either side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module word_request_coalescer_core_test;
    import wrc_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_beat_t req_beat;
    logic      rec_valid;
    logic      rec_stall;
    rec_beat_t rec_beat;

    word_request_coalescer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_beat  (req_beat),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec_beat  (rec_beat)
    );

    // Predicted records, oldest first.
    rec_beat_t record_q[$];

    int unsigned error_count = 0;

    // Idling controls for the sender and the receiver processes.
    bit          send_idle_on = 1'b1;
    bit          recv_idle_on = 1'b1;
    int unsigned hold_off_cycles = 0;

    // Predictor copy of the open-word state.
    bit                 w_open;
    logic [ADDR_W-1:0]  w_addr;
    logic [GROUP_W-1:0] w_group;
    bit                 w_group_open;
    logic [USED_W-1:0]  w_used;
    logic [SUM_W-1:0]   w_updates;
    logic [SUM_W-1:0]   w_sources;
    logic [MASK_W-1:0]  w_mask;
    logic [SUM_W-1:0]   req_total;
    logic [SUM_W-1:0]   peak_updates;

    // Stream generator memory so that runs can revisit the previous word.
    logic [ADDR_W-1:0]  prev_addr = '0;
    logic [GROUP_W-1:0] prev_group = '0;

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [SUM_W-1:0] sum_sat(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] ones_of(input logic [MASK_W-1:0] m);
        return SUM_W'($countones(m));
    endfunction

    function automatic void clear_open_word();
        w_open       = 1'b0;
        w_addr       = '0;
        w_group      = '0;
        w_group_open = 1'b0;
        w_used       = '0;
        w_updates    = '0;
        w_sources    = '0;
        w_mask       = '0;
    endfunction

    // Close the open word into rec; return 1 when a word was open.
    function automatic bit close_open_word(output rec_beat_t rec);
        rec = '0;
        if (!w_open)
            return 1'b0;
        req_total = sum_sat(req_total, 32'd1);
        if (w_updates > peak_updates)
            peak_updates = w_updates;
        rec.word_address         = w_addr;
        rec.coefficients_used    = w_used;
        rec.event_updates        = w_updates;
        rec.source_updates       = sum_sat(w_sources, ones_of(w_mask));
        rec.total_requests       = req_total;
        rec.max_updates_per_word = peak_updates;
        clear_open_word();
        return 1'b1;
    endfunction

    // Apply one accepted request beat; return 1 when it closes a word.
    function automatic bit coalesce_predict(input req_beat_t b, output rec_beat_t rec);
        bit closed;
        rec = '0;
        closed = 1'b0;
        if (b.op == OP_END)
            return close_open_word(rec);
        if (!w_open || b.address != w_addr)
        begin
            closed = close_open_word(rec);
            w_open = 1'b1;
            w_addr = b.address;
        end
        if (!w_group_open || b.group != w_group)
        begin
            w_sources    = sum_sat(w_sources, ones_of(w_mask));
            w_mask       = '0;
            w_group      = b.group;
            w_group_open = 1'b1;
        end
        if (w_used != {USED_W{1'b1}})
            w_used = w_used + 1'b1;
        w_updates = sum_sat(w_updates, ones_of(b.events));
        w_mask    = w_mask | b.events;
        return closed;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: offer one beat, hold it until accepted, then predict
    // ------------------------------------------------------------------------
    task automatic send_beat(input req_beat_t b);
        rec_beat_t rec;
        // Insert a random idle burst; lower valid only here so it never
        // drops and rises in the same step.
        if (send_idle_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_beat  <= b;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (coalesce_predict(b, rec))
            record_q.push_back(rec);
    endtask

    function automatic req_beat_t make_access(input logic [ADDR_W-1:0] a,
                                              input logic [GROUP_W-1:0] g,
                                              input logic [MASK_W-1:0] e);
        req_beat_t b;
        b.op      = OP_ACCESS;
        b.address = a;
        b.group   = g;
        b.events  = e;
        return b;
    endfunction

    // End beats carry random payload; the block ignores it.
    function automatic req_beat_t make_end();
        req_beat_t b;
        b.op      = OP_END;
        b.address = $urandom;
        b.group   = 16'($urandom);
        b.events  = {$urandom, $urandom};
        return b;
    endfunction

    function automatic logic [MASK_W-1:0] pick_events();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, 63);
            3: return {$urandom, $urandom} & {$urandom, $urandom};
            4: return {$urandom, $urandom} | {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3, 4:    return prev_addr + 1'b1;
            5:       return prev_addr;
            6, 7:    return $urandom_range(0, 15);
            8:       return $urandom_range(0, 1) ? '1 : '0;
            default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
        endcase
    endfunction

    // Send well-formed word runs with random content, plus some broken
    // patterns (double ends, ends with nothing open).
    task automatic send_word_runs(input int unsigned n_items);
        int unsigned        sent;
        int unsigned        run_len;
        logic [ADDR_W-1:0]  a;
        logic [GROUP_W-1:0] g;
        sent = 0;
        while (sent < n_items)
        begin
            a = pick_address();
            run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40)
                                                   : $urandom_range(1, 8);
            g = ($urandom_range(0, 3) == 0) ? prev_group : 16'($urandom);
            for (int i = 0; i < run_len; i++)
            begin
                // Change group now and then, to a neighbor or anywhere.
                if (i != 0 && $urandom_range(0, 2) == 0)
                    g = $urandom_range(0, 1) ? g + 1'b1 : 16'($urandom);
                send_beat(make_access(a, g, pick_events()));
                sent++;
            end
            prev_addr  = a;
            prev_group = g;
            if ($urandom_range(0, 5) == 0)
            begin
                send_beat(make_end());
                sent++;
                if ($urandom_range(0, 4) == 0)
                begin
                    send_beat(make_end());
                    sent++;
                end
            end
        end
    endtask

    // Pause the sender until every predicted record has come out.
    task automatic drain_records();
        req_valid <= 1'b0;
        while (record_q.size() != 0)
            @(posedge clk);
        // An access that only opens a word leaves no record; let it settle.
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        send_beat(make_end());                                      // nothing open
        send_beat(make_access('0, '0, '0));                         // first access
        send_beat(make_access('0, '0, '1));
        send_beat(make_access('0, 16'hFFFF, 64'h1));                // group change
        send_beat(make_access('0, 16'hFFFF, 64'h8000_0000_0000_0000));
        send_beat(make_access('1, 16'hFFFF, '1));                   // new word, same group
        send_beat(make_access('1, '0, 64'hAAAA_AAAA_AAAA_AAAA));
        send_beat(make_access('1, '0, 64'h5555_5555_5555_5555));
        send_beat(make_end());                                      // close
        send_beat(make_end());                                      // double end
        send_beat(make_access('1, '0, 64'h0F0F_0F0F_0F0F_0F0F));    // reopen same word
        send_beat(make_access(32'h8000_0000, 16'h8000, '1));
        send_beat(make_access(32'h8000_0000, 16'h0001, '0));
        send_beat(make_access(32'h8000_0000, 16'h8000, '1));        // group revisited
        send_beat(make_access(32'h7FFF_FFFF, 16'h7FFF, 64'h7FFF_FFFF_FFFF_FFFF));
        send_beat(make_end());
    endtask

    task automatic test_random_runs();
        send_word_runs(1000);
    endtask

    // Hold the receiver off while the sender keeps pushing, so the block
    // fills and stalls its input.
    task automatic test_receiver_hold_off();
        // Drop the last beat so it is not taken again while waiting.
        req_valid <= 1'b0;
        hold_off_cycles = 200;
        @(posedge clk);
        while (!rec_stall)
            @(posedge clk);
        send_word_runs(80);
    endtask

    // One word long enough to saturate the used count.
    task automatic test_used_saturation();
        logic [ADDR_W-1:0]  a;
        logic [GROUP_W-1:0] g;
        a = $urandom;
        g = 16'($urandom);
        for (int i = 0; i < 300; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                g = 16'($urandom);
            send_beat(make_access(a, g, ($urandom_range(0, 3) == 0) ? pick_events() : '1));
        end
        send_beat(make_end());
    endtask

    task automatic test_no_idle();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        send_word_runs(250);
        send_beat(make_end());
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall in random bursts, or for one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        rec_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles != 0)
            begin
                rec_stall <= 1'b1;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
                rec_stall <= 1'b0;
            end
            else if (rst_n && recv_idle_on && $urandom_range(0, 7) == 0)
            begin
                rec_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                rec_stall <= 1'b0;
            end
            else
            begin
                rec_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare each accepted record beat with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        rec_beat_t want;
        if (rst_n && rec_valid && !rec_stall)
        begin
            if (record_q.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected record: %p", rec_beat);
            end
            else
            begin
                want = record_q.pop_front();
                if (rec_beat.word_address         !== want.word_address      ||
                    rec_beat.coefficients_used    !== want.coefficients_used ||
                    rec_beat.event_updates        !== want.event_updates     ||
                    rec_beat.source_updates       !== want.source_updates    ||
                    rec_beat.total_requests       !== want.total_requests    ||
                    rec_beat.max_updates_per_word !== want.max_updates_per_word)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("record mismatch: expected %p actual %p", want, rec_beat);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_beat  = '0;
        clear_open_word();
        req_total    = '0;
        peak_updates = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_runs();
        test_receiver_hold_off();
        drain_records();
        test_used_saturation();
        drain_records();
        test_no_idle();

        // Drop valid, wait out the outstanding records, then a short tail.
        req_valid <= 1'b0;
        while (record_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        error_count += record_q.size();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
